// ===== design/running_mean_and_sigma_unit_defines.svh =====
// running_mean_and_sigma_unit_defines.svh
// Assertion macros for the running mean and sigma RTL; no dependencies.
// Define ASSERT_OFF to compile the checks out.
`ifndef RUNNING_MEAN_AND_SIGMA_UNIT_DEFINES_SVH
`define RUNNING_MEAN_AND_SIGMA_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on the rising clock edge
`define RMSIG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge
`define RMSIG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RMSIG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define RMSIG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== design/rmsig_pkg.sv =====
// rmsig_pkg.sv
// Shared constants and the result record of the running mean and sigma unit.
// No dependencies.
package rmsig_pkg;

    localparam int DEF_SAMPLE_WIDTH = 32;
    localparam int DEF_COUNT_WIDTH  = 32;

    // Port field width and fixed-point layout
    localparam int FIELD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int M2_W    = 64;

    // One finished run, as handed from the core to the output register
    typedef struct packed {
        logic [FIELD_W-1:0] mean_value;
        logic [FIELD_W-1:0] sigma;
        logic [FIELD_W-1:0] sample_count;
        logic               overflow;
    } rmsig_result_t;

endpackage

// ===== design/rmsig_alu.sv =====
// rmsig_alu.sv
// Shared add/subtract unit with carry out, used by the arithmetic steps of the sequencer.
// No dependencies.
module rmsig_alu #(
    parameter int WIDTH = 66
)(
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic             sub,
    output logic [WIDTH-1:0] sum,
    output logic             carry
);

    // a + b, or a - b as a + ~b + 1; carry set means no borrow on subtract
    assign {carry, sum} = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{WIDTH{1'b0}}, sub};

endmodule

// ===== design/rmsig_core.sv =====
// rmsig_core.sv
// Sequencer and datapath of the Welford update, divider, multiplier and square root.
// Depends on rmsig_pkg, rmsig_alu and running_mean_and_sigma_unit_defines.svh.
`include "running_mean_and_sigma_unit_defines.svh"

module rmsig_core
    import rmsig_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FIELD_W-1:0] sample,
    input  logic               last,
    output logic               res_push,
    input  logic               res_free,
    output rmsig_result_t      result
);

    localparam int MW         = SAMPLE_WIDTH + FRAC_W;      // Q16.32 mean width
    localparam int CW         = COUNT_WIDTH;
    localparam int DQ_W       = M2_W;                       // divider / root register
    localparam int AW         = ((MW > M2_W) ? MW : M2_W) + 2;
    localparam int IW         = $clog2(DQ_W);
    localparam int ALIGN      = DQ_W - MW;
    localparam int SQRT_STEPS = DQ_W / 2;
    localparam int WIDE_W     = 2 * DQ_W;
    localparam int INC_LSB    = 2 * (2 * FRAC_W) - FRAC_W;  // Q.64 product to Q.16
    localparam int SIG_LIM    = M2_W - FRAC_W;
    localparam int CLAMP_LSB  = FRAC_W + FIELD_W - 1;
    localparam logic [FRAC_W-1:0] ROUND_HALF = FRAC_W'(1) << (FRAC_W - 1);

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_DIFF = 13'b0000000000010,
        ST_ABS  = 13'b0000000000100,
        ST_DIV  = 13'b0000000001000,
        ST_ERR  = 13'b0000000010000,
        ST_MEAN = 13'b0000000100000,
        ST_MUL  = 13'b0000001000000,
        ST_ACC  = 13'b0000010000000,
        ST_VDEC = 13'b0000100000000,
        ST_VDIV = 13'b0001000000000,
        ST_VCHK = 13'b0010000000000,
        ST_SQRT = 13'b0100000000000,
        ST_OUT  = 13'b1000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [MW-1:0]     mean_reg, mean_next;
    logic [M2_W-1:0]   m2_reg, m2_next;
    logic              sat_reg, sat_next;

    logic [MW-1:0]     x_reg, x_next;
    logic              last_reg, last_next;
    logic              neg_reg, neg_next;
    logic [MW-1:0]     mag_reg, mag_next;
    logic [DQ_W-1:0]   dq_reg, dq_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [CW-1:0]     dvs_reg, dvs_next;
    logic [MW-1:0]     prod_hi_reg, prod_hi_next;
    logic [MW-1:0]     prod_lo_reg, prod_lo_next;
    logic [DQ_W-1:0]   res_reg, res_next;
    logic [DQ_W-1:0]   bit_reg, bit_next;
    logic [IW-1:0]     iter_reg, iter_next;
    logic [FIELD_W-1:0] sigma_reg, sigma_next;

    logic [AW-1:0]     alu_a, alu_b, alu_sum;
    logic              alu_sub, alu_carry;

    logic [DQ_W-1:0]   sample_wide;
    logic [SAMPLE_WIDTH-1:0] sx;
    logic [CW:0]       div_shift;
    logic [WIDE_W-1:0] prod_wide;
    logic [M2_W-1:0]   inc;
    logic              mul_sat;
    logic [AW-CLAMP_LSB-1:0] clamp_bits;
    logic [DQ_W-1:0]   count_wide;

    function automatic logic [AW-1:0] sext(input logic [MW-1:0] v);
        sext = {{(AW-MW){v[MW-1]}}, v};
    endfunction

    // Take the sample as SAMPLE_WIDTH bits; higher bits are ignored
    assign sample_wide = DQ_W'(sample);
    assign sx          = sample_wide[SAMPLE_WIDTH-1:0];

    assign div_shift = {rem_reg, dq_reg[DQ_W-1]};

    // Product of |delta| and the error term, moved to Q48.16
    assign prod_wide = WIDE_W'({prod_hi_reg, prod_lo_reg});
    assign inc       = prod_wide[INC_LSB+M2_W-1:INC_LSB];
    assign mul_sat   = |prod_wide[WIDE_W-1:INC_LSB+M2_W];

    rmsig_alu #(
        .WIDTH (AW)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    // Select operands of the shared unit for the current step
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_DIFF:
            begin
                alu_a   = sext(x_reg);
                alu_b   = sext(mean_reg);
                alu_sub = 1'b1;
            end
            ST_ABS:
            begin
                alu_a   = neg_reg ? sext(mean_reg) : sext(x_reg);
                alu_b   = neg_reg ? sext(x_reg) : sext(mean_reg);
                alu_sub = 1'b1;
            end
            ST_DIV, ST_VDIV:
            begin
                alu_a   = AW'(div_shift);
                alu_b   = AW'(dvs_reg);
                alu_sub = 1'b1;
            end
            ST_ERR:
            begin
                alu_a   = AW'(mag_reg);
                alu_b   = AW'(dq_reg[MW-1:0]);
                alu_sub = 1'b1;
            end
            ST_MEAN:
            begin
                alu_a   = sext(mean_reg);
                alu_b   = AW'(dq_reg[MW-1:0]);
                alu_sub = neg_reg;
            end
            ST_MUL:
            begin
                alu_a = AW'(prod_hi_reg);
                alu_b = prod_lo_reg[0] ? AW'(mag_reg) : '0;
            end
            ST_ACC:
            begin
                alu_a = AW'(m2_reg);
                alu_b = AW'(inc);
            end
            ST_VDEC:
            begin
                alu_a   = AW'(count_reg);
                alu_b   = AW'(1'b1);
                alu_sub = 1'b1;
            end
            ST_SQRT:
            begin
                alu_a   = AW'(dq_reg);
                alu_b   = AW'(res_reg | bit_reg);
                alu_sub = 1'b1;
            end
            ST_OUT:
            begin
                alu_a = sext(mean_reg);
                alu_b = AW'(ROUND_HALF);
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    // Sequencer and register updates
    always_comb
    begin
        logic [DQ_W-1:0] res_step;

        state_next   = state_reg;
        count_next   = count_reg;
        mean_next    = mean_reg;
        m2_next      = m2_reg;
        sat_next     = sat_reg;
        x_next       = x_reg;
        last_next    = last_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        dq_next      = dq_reg;
        rem_next     = rem_reg;
        dvs_next     = dvs_reg;
        prod_hi_next = prod_hi_reg;
        prod_lo_next = prod_lo_reg;
        res_next     = res_reg;
        bit_next     = bit_reg;
        iter_next    = iter_reg;
        sigma_next   = sigma_reg;
        res_push     = 1'b0;
        res_step     = alu_carry ? ((res_reg >> 1) | bit_reg) : (res_reg >> 1);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next    = {sx, {FRAC_W{1'b0}}};
                    last_next = last;
                    // Hold the count at its ceiling and flag it
                    if (&count_reg)
                    begin
                        sat_next = 1'b1;
                        dvs_next = count_reg;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        dvs_next   = count_reg + 1'b1;
                    end
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                neg_next   = alu_sum[AW-1];
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                mag_next   = alu_sum[MW-1:0];
                dq_next    = DQ_W'(alu_sum[MW-1:0]) << ALIGN;
                rem_next   = '0;
                iter_next  = IW'(MW - 1);
                state_next = ST_DIV;
            end
            ST_DIV, ST_VDIV:
            begin
                // One restoring quotient bit per cycle
                rem_next  = alu_carry ? alu_sum[CW-1:0] : div_shift[CW-1:0];
                dq_next   = {dq_reg[DQ_W-2:0], alu_carry};
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    state_next = (state_reg == ST_DIV) ? ST_ERR : ST_VCHK;
                end
            end
            ST_ERR:
            begin
                prod_lo_next = alu_sum[MW-1:0];
                prod_hi_next = '0;
                iter_next    = IW'(MW - 1);
                state_next   = ST_MEAN;
            end
            ST_MEAN:
            begin
                mean_next  = alu_sum[MW-1:0];
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                // Shift-add: one multiplier bit per cycle
                prod_hi_next = alu_sum[MW:1];
                prod_lo_next = {alu_sum[0], prod_lo_reg[MW-1:1]};
                iter_next    = iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (alu_sum[M2_W] || mul_sat)
                begin
                    m2_next  = '1;
                    sat_next = 1'b1;
                end
                else
                begin
                    m2_next = alu_sum[M2_W-1:0];
                end
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (|count_reg[CW-1:1])
                begin
                    state_next = ST_VDEC;
                end
                else
                begin
                    // Single sample in the run: no spread
                    sigma_next = '0;
                    state_next = ST_OUT;
                end
            end
            ST_VDEC:
            begin
                dvs_next   = alu_sum[CW-1:0];
                dq_next    = m2_reg;
                rem_next   = '0;
                iter_next  = IW'(DQ_W - 1);
                state_next = ST_VDIV;
            end
            ST_VCHK:
            begin
                if (|dq_reg[DQ_W-1:SIG_LIM])
                begin
                    sigma_next = '1;
                    state_next = ST_OUT;
                end
                else
                begin
                    dq_next    = dq_reg << FRAC_W;
                    res_next   = '0;
                    bit_next   = DQ_W'(1) << (DQ_W - 2);
                    iter_next  = IW'(SQRT_STEPS - 1);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                // One root bit per cycle, remainder kept in dq
                if (alu_carry)
                begin
                    dq_next = alu_sum[DQ_W-1:0];
                end
                res_next  = res_step;
                bit_next  = bit_reg >> 2;
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    sigma_next = res_step[FIELD_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Hand over the run and clear for the next one
                if (res_free)
                begin
                    res_push   = 1'b1;
                    count_next = '0;
                    mean_next  = '0;
                    m2_next    = '0;
                    sat_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            mean_reg  <= '0;
            m2_reg    <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            mean_reg  <= mean_next;
            m2_reg    <= m2_next;
            sat_reg   <= sat_next;
        end
    end

    // Working registers of the shared unit
    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        last_reg    <= last_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        dq_reg      <= dq_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        prod_hi_reg <= prod_hi_next;
        prod_lo_reg <= prod_lo_next;
        res_reg     <= res_next;
        bit_reg     <= bit_next;
        iter_reg    <= iter_next;
        sigma_reg   <= sigma_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Round the mean to Q16.16 and clamp to the signed 32-bit range
    assign clamp_bits = alu_sum[AW-1:CLAMP_LSB];
    assign count_wide = DQ_W'(count_reg);

    always_comb
    begin
        if ((&clamp_bits) || !(|clamp_bits))
        begin
            result.mean_value = alu_sum[CLAMP_LSB:FRAC_W];
        end
        else
        begin
            result.mean_value = {alu_sum[AW-1], {(FIELD_W-1){~alu_sum[AW-1]}}};
        end
        result.sigma        = sigma_reg;
        result.sample_count = (|count_wide[DQ_W-1:FIELD_W]) ? '1 : count_wide[FIELD_W-1:0];
        result.overflow     = sat_reg;
    end

    `RMSIG_ASSERT_IMP(a_push_free, clk, rst_n, res_push, res_free, "result pushed into a full output register")
    `RMSIG_ASSERT_IMP(a_count_live, clk, rst_n, state_reg != ST_IDLE, count_reg != '0, "busy with a zero sample count")
    `RMSIG_ASSERT_IMP(a_rem_below, clk, rst_n, (state_reg == ST_DIV) || (state_reg == ST_VDIV), rem_reg < dvs_reg, "divider remainder not below divisor")
    `RMSIG_ASSERT_NXT(a_push_clears, clk, rst_n, res_push, (count_reg == '0) && (m2_reg == '0) && !sat_reg, "run state not cleared after result")
    `RMSIG_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready, "ready held after a sample transfer")

endmodule

// ===== design/running_mean_and_sigma_unit.sv =====
// Running mean and sigma unit: Welford update of signed Q16.16 samples.
// Slave stream: s_axis_tdata carries one sample, s_axis_tlast marks the end of a run.
// Master stream: one result per run with mean, sample sigma, count and overflow flag.
// Each sample runs from transfer to ready again through a bit-serial divide by the
// count and a shift-add multiply, both on the one shared adder. A sample with tlast
// adds a 64-step division of the squared-deviation sum by count-1, a 32-step square
// root, and the result hand-over.
// s_axis_tready is high only while the sequencer is idle.
// The result sits in an output register; when the receiver stalls, the unit still takes
// and processes samples of the next run and waits at the next result only while the
// register is still full.
// Reset clears the run state (count, mean, sum, flag) and drops any waiting result.
// Count and squared-deviation sum saturate and set the overflow flag (tuser).
// Depends on rmsig_pkg, rmsig_core and rmsig_alu.
module running_mean_and_sigma_unit
    import rmsig_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [FIELD_W-1:0]   s_axis_tdata,   // [31:0] sample
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [3*FIELD_W-1:0] m_axis_tdata,   // [31:0] mean_value, [63:32] sigma,
                                                 // [95:64] sample_count
    output logic                 m_axis_tuser    // [0] overflow
);

    rmsig_result_t core_result;
    rmsig_result_t out_reg;
    logic          out_valid_reg, out_valid_next;
    logic          res_push;
    logic          res_free;

    rmsig_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sample   (s_axis_tdata),
        .last     (s_axis_tlast),
        .res_push (res_push),
        .res_free (res_free),
        .result   (core_result)
    );

    // Output register frees when empty or when its transfer completes
    assign res_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        if (res_push)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result record on push
    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            out_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.sample_count, out_reg.sigma, out_reg.mean_value};
    assign m_axis_tuser  = out_reg.overflow;

endmodule

// ===== test/run_summary_checker.sv =====
// run_summary_checker.sv
// Watches both streams of the running mean and sigma unit, predicts each run summary
// and compares it field by field. Depends on rmsig_pkg.
module run_summary_checker
    import rmsig_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [FIELD_W-1:0]   s_axis_tdata,   // [31:0] sample
    input  logic                 s_axis_tlast,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [3*FIELD_W-1:0] m_axis_tdata,   // [31:0] mean_value, [63:32] sigma,
                                                 // [95:64] sample_count
    input  logic                 m_axis_tuser,   // [0] overflow
    output int                   mismatches,
    output int                   open_runs,
    output int                   summaries_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint MEAN_MAX = 64'sd2147483647;
    localparam longint MEAN_MIN = -64'sd2147483648;

    // Run state of the prediction: count, Q16.32 mean, Q48.16 squared-deviation sum
    logic [DEF_COUNT_WIDTH-1:0] run_count;
    longint                     mean_q32;
    logic [M2_W-1:0]            dev_sq_sum;
    bit                         run_overflow;

    rmsig_result_t expected_summaries[$];

    // Integer square root, one result bit per step from the top down
    function automatic logic [31:0] floor_sqrt(input logic [63:0] radicand);
        logic [31:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = 64'(root | (32'd1 << b));
            if (trial * trial <= radicand)
                root = root | (32'd1 << b);
        end
        return root;
    endfunction

    // Fold one sample into the run with the Welford update
    task automatic fold_sample(input logic [FIELD_W-1:0] raw);
        longint       x;
        logic [63:0]  mag;
        logic [63:0]  step;
        logic [63:0]  rest;
        logic [63:0]  inc;
        logic [127:0] prod;
        logic [64:0]  total;
        bit           toward_low;
        x = longint'(signed'(raw)) <<< FRAC_W;
        if (&run_count)
            run_overflow = 1'b1;
        else
            run_count++;
        toward_low = x < mean_q32;
        mag  = toward_low ? mean_q32 - x : x - mean_q32;
        step = mag / 64'(run_count);
        rest = mag - step;
        mean_q32 = toward_low ? mean_q32 - longint'(step) : mean_q32 + longint'(step);
        // Increment is |delta| * (|delta| - step) >> 48, saturating
        prod = 128'(mag) * 128'(rest);
        if (prod[127:112] != '0)
        begin
            inc = '1;
            run_overflow = 1'b1;
        end
        else
            inc = prod[111:48];
        total = 65'(dev_sq_sum) + 65'(inc);
        if (total[64])
        begin
            dev_sq_sum = '1;
            run_overflow = 1'b1;
        end
        else
            dev_sq_sum = total[63:0];
    endtask

    // Form the summary of the finished run and clear the run state
    task automatic close_run(output rmsig_result_t summary);
        logic [63:0] biased;
        logic [63:0] variance;
        longint      rounded;
        biased  = mean_q32 + 64'h8000;
        rounded = longint'(biased) >>> FRAC_W;
        if (rounded > MEAN_MAX)
            rounded = MEAN_MAX;
        else if (rounded < MEAN_MIN)
            rounded = MEAN_MIN;
        summary.mean_value = rounded[31:0];
        summary.sigma = '0;
        // A single sample has no spread
        if (run_count >= 2)
        begin
            variance = dev_sq_sum / (64'(run_count) - 64'd1);
            if (variance >= (64'd1 << 48))
                summary.sigma = '1;
            else
                summary.sigma = floor_sqrt(variance << FRAC_W);
        end
        summary.sample_count = 32'(run_count);
        summary.overflow     = run_overflow;
        run_count    = '0;
        mean_q32     = 0;
        dev_sq_sum   = '0;
        run_overflow = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Check result transfers first, then fold input transfers of the same edge
    always @(posedge clk)
    begin : watch_streams
        rmsig_result_t want;
        rmsig_result_t fresh;
        if (!rst_n)
        begin
            run_count    = '0;
            mean_q32     = 0;
            dev_sq_sum   = '0;
            run_overflow = 1'b0;
            expected_summaries.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_summaries.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result with no run pending, expected none, got %h/%b",
                             $time, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = expected_summaries.pop_front();
                    check_field("mean_value", want.mean_value, m_axis_tdata[31:0]);
                    check_field("sigma", want.sigma, m_axis_tdata[63:32]);
                    check_field("sample_count", want.sample_count, m_axis_tdata[95:64]);
                    check_field("overflow", 32'(want.overflow), 32'(m_axis_tuser));
                    summaries_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                fold_sample(s_axis_tdata);
                if (s_axis_tlast)
                begin
                    close_run(fresh);
                    // Append at the tail so summaries leave in run order
                    expected_summaries.insert(expected_summaries.size(), fresh);
                end
            end
        end
        open_runs = expected_summaries.size();
    end

endmodule

// ===== test/running_mean_and_sigma_unit_tb.sv =====
// running_mean_and_sigma_unit_tb.sv
// Top of the testbench: clock, reset, sample runs and receiver stalls for the unit.
// Depends on rmsig_pkg, running_mean_and_sigma_unit and run_summary_checker.
module running_mean_and_sigma_unit_tb;
    import rmsig_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SAMPLE_TARGET = 850;
    localparam int unsigned HOLD_CYCLES   = 3000;
    localparam int unsigned SETTLE_CYCLES = 300;
    localparam int unsigned LIMIT_CYCLES  = 1_500_000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [FIELD_W-1:0]   s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [3*FIELD_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    int          mismatches;
    int          open_runs;
    int          summaries_checked;
    int unsigned samples_sent = 0;
    int unsigned runs_sent = 0;
    int unsigned run_length = 0;
    int unsigned longest_run = 0;
    bit          hold_output = 1'b0;

    running_mean_and_sigma_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    run_summary_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .s_axis_tlast      (s_axis_tlast),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .m_axis_tuser      (m_axis_tuser),
        .mismatches        (mismatches),
        .open_runs         (open_runs),
        .summaries_checked (summaries_checked)
    );

    initial
    begin : clock_gen
        forever #10 clk = ~clk;
    end

    initial
    begin : reset_seq
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // End the simulation if it reaches the cycle limit
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d runs still open", cycles, open_runs);
        $display("Test completed with failures");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Offer one sample and hold it until the transfer
    task automatic offer_sample(input logic [FIELD_W-1:0] value, input logic end_of_run);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= end_of_run;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        samples_sent++;
        run_length++;
        if (end_of_run)
        begin
            runs_sent++;
            if (run_length > longest_run)
                longest_run = run_length;
            run_length = 0;
        end
    endtask

    // Drop valid for a number of cycles, with junk on the data lines
    task automatic pause_sender(input int unsigned cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tlast  <= 1'($urandom_range(0, 1));
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    task automatic offer_with_gap(input logic [FIELD_W-1:0] value, input logic end_of_run);
        offer_sample(value, end_of_run);
        pause_sender(pick_gap());
    endtask

    // Sample around the run's center, with wide values and extremes mixed in
    function automatic logic [FIELD_W-1:0] pick_sample(input logic [FIELD_W-1:0] center);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return $urandom;
        else if (roll < 75)
            return center + $urandom_range(0, 8191) - 32'd4096;
        else if (roll < 90)
            return center + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic int unsigned pick_run_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 6);
        else if (roll < 95)
            return $urandom_range(7, 30);
        return $urandom_range(50, 120);
    endfunction

    // Receiver: random ready stretches, forced low during the hold-off
    initial
    begin : drain_side
        int unsigned roll;
        int unsigned stretch;
        bit          level;
        forever
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
            begin
                level   = 1'b1;
                stretch = $urandom_range(100, 400);
            end
            else if (roll < 80)
            begin
                level   = ($urandom_range(0, 99) < 65);
                stretch = $urandom_range(1, 4);
            end
            else
            begin
                level   = ($urandom_range(0, 99) < 50);
                stretch = $urandom_range(10, 60);
            end
            repeat (stretch)
            begin
                @(negedge clk);
                m_axis_tready <= level && !hold_output;
            end
        end
    end

    // Hold off the receiver long enough for the unit to back up its input
    initial
    begin : back_pressure
        wait (samples_sent >= 300);
        @(posedge clk);
        hold_output = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
    end

    initial
    begin : stimulus
        int unsigned       length;
        logic [FIELD_W-1:0] center;
        wait (rst_n);

        // Single-sample runs at both extremes: sigma is zero
        offer_with_gap(32'h7FFF_FFFF, 1'b1);
        offer_with_gap(32'h8000_0000, 1'b1);
        // Widest possible spread
        offer_with_gap(32'h8000_0000, 1'b0);
        offer_with_gap(32'h7FFF_FFFF, 1'b1);
        // Constant zeros
        offer_with_gap(32'h0000_0000, 1'b0);
        offer_with_gap(32'h0000_0000, 1'b0);
        offer_with_gap(32'h0000_0000, 1'b1);
        // Negative half-LSB means: round toward plus infinity
        offer_with_gap(32'hFFFF_FFFF, 1'b0);
        offer_with_gap(32'h0000_0000, 1'b1);
        offer_with_gap(32'hFFFF_FFFF, 1'b0);
        offer_with_gap(32'hFFFF_FFFE, 1'b1);
        // Alternating extremes
        for (int k = 0; k < 6; k++)
            offer_with_gap(k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, k == 5);
        // Repeated mid-range value
        for (int k = 0; k < 3; k++)
            offer_with_gap(32'h1234_5678, k == 2);

        // Random runs until the sample budget is spent
        while (samples_sent < SAMPLE_TARGET)
        begin
            length = pick_run_length();
            center = $urandom;
            for (int k = 0; k < length; k++)
                offer_with_gap(pick_sample(center), k == length - 1);
        end
        pause_sender(1);

        // Drain, then let the unit settle
        @(negedge clk);
        wait (open_runs == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d samples in %0d runs (longest %0d), %0d summaries checked.",
                 samples_sent, runs_sent, longest_run, summaries_checked);
        $display("Both sides idled at random; the receiver once stalled for %0d cycles.",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== running_mean_and_sigma_unit.f =====
+incdir+design
design/rmsig_pkg.sv
design/rmsig_alu.sv
design/rmsig_core.sv
design/running_mean_and_sigma_unit.sv
test/run_summary_checker.sv
test/running_mean_and_sigma_unit_tb.sv
